// ===== hdl/fbsc_pkg.sv =====
// shared constants for the frustum box/sphere cull block
// no dependencies
package fbsc_pkg;

  localparam int PlaneCount   = 4;
  localparam int AxisCount    = 3;
  localparam int RegCount     = 2 * PlaneCount;
  localparam int ApbDataWidth = 64;
  localparam int RegIdxWidth  = $clog2(RegCount);
  localparam int ApbAddrWidth = RegIdxWidth + 3;

  // register map: normals first, then distances, 8 bytes apart
  localparam logic [RegIdxWidth-1:0] RegNormalBase = RegIdxWidth'(0);
  localparam logic [RegIdxWidth-1:0] RegDistBase   = RegIdxWidth'(PlaneCount);

endpackage

// ===== hdl/fbsc_in_if.sv =====
// input item channel of the cull block: entity origin, box and radius
// no dependencies
interface fbsc_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic                          is_rotated;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic        [COORD_WIDTH-2:0] bound_radius;

  modport source (
    output valid, is_rotated, pos_x, pos_y, pos_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           bound_radius,
    input  ready
  );
  modport sink (
    input  valid, is_rotated, pos_x, pos_y, pos_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           bound_radius,
    output ready
  );
endinterface

// ===== hdl/fbsc_out_if.sv =====
// result item channel of the cull block
// no dependencies
interface fbsc_out_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink (input valid, culled, output ready);
endinterface

// ===== hdl/frustum_box_sphere_cull.sv =====
// channel   dir  handshake       payload
// in_i      in   valid/ready     is_rotated, pos, box_min, box_max, bound_radius
// out_o     out  valid/ready     culled
// apb       in   psel/penable    plane normals and distances, 64-bit data
//
// one item per cycle sustained while out_o is ready; each stage below registers the item
// stages: input/corner-sum register, product register, compare register
// each stage holds its item while the next one is full and stalled
// rst_ni clears the stage valids and the plane registers to zero
// depends on fbsc_pkg, fbsc_in_if, fbsc_out_if
module frustum_box_sphere_cull #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fbsc_in_if.sink                           in_i,
  fbsc_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fbsc_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [fbsc_pkg::ApbDataWidth-1:0] pwdata,
  output logic [fbsc_pkg::ApbDataWidth-1:0] prdata,
  output logic                              pready
);
  import fbsc_pkg::*;

  localparam int NW       = NORMAL_WIDTH;
  localparam int CW       = COORD_WIDTH;
  localparam int FracBits = NW - 2;
  localparam int NormW    = 3 * NW;
  localparam int ExtW     = CW + 1;
  localparam int ProdW    = ExtW + NW;
  localparam int DotW     = ProdW + 2;
  localparam int ThrW     = CW + 1;

  // plane registers
  logic        [NormW-1:0] normal_q [PlaneCount];
  logic signed [CW-1:0]    dist_q   [PlaneCount];
  logic [RegIdxWidth-1:0]  reg_idx;
  logic                    cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrWidth-1:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PlaneCount; p++) begin
        normal_q[p] <= '0;
        dist_q[p]   <= '0;
      end
    end else if (cfg_we) begin
      if (reg_idx < RegDistBase) begin
        normal_q[reg_idx[RegIdxWidth-2:0]] <= pwdata[NormW-1:0];
      end else begin
        dist_q[reg_idx[RegIdxWidth-2:0]] <= pwdata[CW-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx < RegDistBase) begin
      prdata = ApbDataWidth'(normal_q[reg_idx[RegIdxWidth-2:0]]);
    end else begin
      prdata = ApbDataWidth'(unsigned'(dist_q[reg_idx[RegIdxWidth-2:0]]));
    end
  end

  // stage handshake
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  assign c_ready    = !c_valid_q || out_o.ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_i.ready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_i.valid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // stage a: origin and absolute box corners
  logic signed [CW-1:0]   in_pos [AxisCount];
  logic signed [CW-1:0]   in_min [AxisCount];
  logic signed [CW-1:0]   in_max [AxisCount];
  logic signed [ExtW-1:0] a_pos_d [AxisCount];
  logic signed [ExtW-1:0] a_lo_d  [AxisCount];
  logic signed [ExtW-1:0] a_hi_d  [AxisCount];
  logic signed [ExtW-1:0] a_pos_q [AxisCount];
  logic signed [ExtW-1:0] a_lo_q  [AxisCount];
  logic signed [ExtW-1:0] a_hi_q  [AxisCount];
  logic                   a_rot_q;
  logic [CW-2:0]          a_rad_q;

  assign in_pos[0] = in_i.pos_x;
  assign in_pos[1] = in_i.pos_y;
  assign in_pos[2] = in_i.pos_z;
  assign in_min[0] = in_i.box_min_x;
  assign in_min[1] = in_i.box_min_y;
  assign in_min[2] = in_i.box_min_z;
  assign in_max[0] = in_i.box_max_x;
  assign in_max[1] = in_i.box_max_y;
  assign in_max[2] = in_i.box_max_z;

  always_comb begin
    for (int a = 0; a < AxisCount; a++) begin
      a_pos_d[a] = {in_pos[a][CW-1], in_pos[a]};
      a_lo_d[a]  = a_pos_d[a] + {in_min[a][CW-1], in_min[a]};
      a_hi_d[a]  = a_pos_d[a] + {in_max[a][CW-1], in_max[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      a_pos_q <= a_pos_d;
      a_lo_q  <= a_lo_d;
      a_hi_q  <= a_hi_d;
      a_rot_q <= in_i.is_rotated;
      a_rad_q <= in_i.bound_radius;
    end
  end

  // stage b: per-plane products and thresholds
  logic signed [NW-1:0]    b_norm  [PlaneCount][AxisCount];
  logic signed [ExtW-1:0]  b_coord [PlaneCount][AxisCount];
  logic signed [ProdW-1:0] b_prod_d [PlaneCount][AxisCount];
  logic signed [ProdW-1:0] b_prod_q [PlaneCount][AxisCount];
  logic signed [ThrW-1:0]  b_thr_d [PlaneCount];
  logic signed [ThrW-1:0]  b_thr_q [PlaneCount];
  logic                    b_rot_q;

  always_comb begin
    for (int p = 0; p < PlaneCount; p++) begin
      for (int a = 0; a < AxisCount; a++) begin
        b_norm[p][a]  = normal_q[p][a*NW +: NW];
        if (a_rot_q) begin
          b_coord[p][a] = a_pos_q[a];
        end else if (b_norm[p][a][NW-1]) begin
          b_coord[p][a] = a_lo_q[a];
        end else begin
          b_coord[p][a] = a_hi_q[a];
        end
        b_prod_d[p][a] = b_coord[p][a] * b_norm[p][a];
      end
      // sphere: dot <= d - r, box: dot < d
      if (a_rot_q) begin
        b_thr_d[p] = {dist_q[p][CW-1], dist_q[p]} - {2'b00, a_rad_q};
      end else begin
        b_thr_d[p] = {dist_q[p][CW-1], dist_q[p]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_prod_q <= b_prod_d;
      b_thr_q  <= b_thr_d;
      b_rot_q  <= a_rot_q;
    end
  end

  // stage c: dot sums and compare
  logic signed [DotW-1:0] c_dot [PlaneCount];
  logic signed [DotW-1:0] c_thr [PlaneCount];
  logic                   c_culled_d;
  logic                   c_culled_q;

  always_comb begin
    c_culled_d = 1'b0;
    for (int p = 0; p < PlaneCount; p++) begin
      c_dot[p] = {{2{b_prod_q[p][0][ProdW-1]}}, b_prod_q[p][0]}
               + {{2{b_prod_q[p][1][ProdW-1]}}, b_prod_q[p][1]}
               + {{2{b_prod_q[p][2][ProdW-1]}}, b_prod_q[p][2]};
      c_thr[p] = {{(DotW-ThrW-FracBits){b_thr_q[p][ThrW-1]}}, b_thr_q[p],
                  {FracBits{1'b0}}};
      if (b_rot_q) begin
        c_culled_d = c_culled_d | (c_dot[p] <= c_thr[p]);
      end else begin
        c_culled_d = c_culled_d | (c_dot[p] < c_thr[p]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_culled_q <= c_culled_d;
    end
  end

  assign out_o.valid  = c_valid_q;
  assign out_o.culled = c_culled_q;

  a_fill_from_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(c_valid_q) |-> $past(b_valid_q))
    else $error("result stage filled without an item in the product stage");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_ready |-> !in_i.ready)
    else $error("item accepted while the input stage is blocked");

  a_b_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !c_ready |=> b_valid_q && $stable(b_rot_q) && $stable(b_thr_q[0]))
    else $error("product stage lost its item during a stall");

  a_dist_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && reg_idx == RegDistBase |=> dist_q[0] == $past(pwdata[CW-1:0]))
    else $error("plane distance write not taken");

endmodule

// ===== tb/sv/cull_monitor.sv =====
`timescale 1ns / 1ps
// watcher for the frustum cull block: follows plane register writes, predicts culled
// for each accepted entity and compares it with each accepted result
// depends on fbsc_pkg, fbsc_in_if, fbsc_out_if
module cull_monitor #(
  parameter int COORD_W = 24,
  parameter int NORM_W  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fbsc_in_if                                in_ch,
  fbsc_out_if                               out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [fbsc_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [fbsc_pkg::ApbDataWidth-1:0] pwdata,
  output int                                fail_count_o,
  output int                                pending_o
);
  import fbsc_pkg::*;

  localparam longint Scale = longint'(1) << (NORM_W - 2);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct packed {
    logic             rotated;
    coord_t           pos_x, pos_y, pos_z;
    coord_t           min_x, min_y, min_z;
    coord_t           max_x, max_y, max_z;
    logic [COORD_W-2:0] radius;
  } ent_rec_t;

  logic signed [NORM_W-1:0]  normal_q [PlaneCount][AxisCount];
  logic signed [COORD_W-1:0] dist_q   [PlaneCount];
  bit culled_q [$];
  int fails = 0;
  int pending = 0;
  int results_seen = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic bit entity_culled(ent_rec_t e);
    longint p [AxisCount];
    longint lo [AxisCount];
    longint hi [AxisCount];
    longint r, d, n, c, dot;
    int i, a;
    bit hit;
    p[0] = e.pos_x;
    p[1] = e.pos_y;
    p[2] = e.pos_z;
    lo[0] = p[0] + longint'(e.min_x);
    lo[1] = p[1] + longint'(e.min_y);
    lo[2] = p[2] + longint'(e.min_z);
    hi[0] = p[0] + longint'(e.max_x);
    hi[1] = p[1] + longint'(e.max_y);
    hi[2] = p[2] + longint'(e.max_z);
    r = longint'({1'b0, e.radius});
    hit = 1'b0;
    for (i = 0; i < PlaneCount; i++) begin
      d = dist_q[i];
      d = d * Scale;
      dot = 0;
      for (a = 0; a < AxisCount; a++) begin
        n = normal_q[i][a];
        if (e.rotated) c = p[a];
        else c = (n < 0) ? lo[a] : hi[a];
        dot += n * c;
      end
      if (e.rotated) begin
        if (dot - d <= -(r * Scale)) hit = 1'b1;
      end else if (dot < d) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic report(string msg);
    fails++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int p, a;
    logic [RegIdxWidth-1:0] idx;
    ent_rec_t e;
    bit want;
    if (!rst_ni) begin
      for (p = 0; p < PlaneCount; p++) begin
        for (a = 0; a < AxisCount; a++) normal_q[p][a] = '0;
        dist_q[p] = '0;
      end
      culled_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ApbAddrWidth-1:3];
        if (idx >= RegDistBase) begin
          dist_q[idx - RegDistBase] = pwdata[COORD_W-1:0];
        end else begin
          for (a = 0; a < AxisCount; a++)
            normal_q[idx - RegNormalBase][a] = pwdata[a*NORM_W +: NORM_W];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        e.rotated = in_ch.is_rotated;
        e.pos_x   = in_ch.pos_x;
        e.pos_y   = in_ch.pos_y;
        e.pos_z   = in_ch.pos_z;
        e.min_x   = in_ch.box_min_x;
        e.min_y   = in_ch.box_min_y;
        e.min_z   = in_ch.box_min_z;
        e.max_x   = in_ch.box_max_x;
        e.max_y   = in_ch.box_max_y;
        e.max_z   = in_ch.box_max_z;
        e.radius  = in_ch.bound_radius;
        culled_q.push_back(entity_culled(e));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (culled_q.size() == 0) begin
          report($sformatf("result %0d arrived with no entity pending", results_seen));
        end else begin
          want = culled_q.pop_front();
          if (out_ch.culled !== want)
            report($sformatf("result %0d culled %b, predicted %b",
                             results_seen, out_ch.culled, want));
        end
      end
      pending = culled_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// top of the frustum cull testbench: clock, reset, plane programming over apb,
// entity stimulus with random gaps and result backpressure, final verdict
// depends on fbsc_pkg, fbsc_in_if, fbsc_out_if, frustum_box_sphere_cull, cull_monitor
module testbench;
  import fbsc_pkg::*;

  localparam int CoordW        = 24;
  localparam int NormW         = 16;
  localparam int LatencyCycles = 3;
  localparam int CycleLimit    = 400000;
  localparam int PhaseItems    = 100;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct packed {
    logic              rotated;
    coord_t            pos_x, pos_y, pos_z;
    coord_t            min_x, min_y, min_z;
    coord_t            max_x, max_y, max_z;
    logic [CoordW-2:0] radius;
  } ent_rec_t;
  typedef enum int {PlanesSlab, PlanesExtreme, PlanesRandom, PlanesSparse} plane_set_e;

  localparam coord_t SlabHalf = 24'sh010000;
  localparam coord_t CoordMax = 24'sh7fffff;
  localparam coord_t CoordMin = -24'sh800000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic pready;

  fbsc_in_if #(.COORD_WIDTH(CoordW)) in_ch ();
  fbsc_out_if out_ch ();

  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;
  int rotated_sent = 0;
  int settings_count = 0;
  bit steady = 1'b0;

  logic [3*NormW-1:0] normals [PlaneCount];
  coord_t             dists   [PlaneCount];

  frustum_box_sphere_cull #(
    .COORD_WIDTH (CoordW),
    .NORMAL_WIDTH(NormW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cull_monitor #(
    .COORD_W(CoordW),
    .NORM_W (NormW)
  ) cull_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result backpressure: short and long stalls, long open stretches
  initial begin
    int r, len;
    logic v;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        v = 1'b1;
        len = $urandom_range(1, 12);
      end else if (r < 65) begin
        v = 1'b1;
        len = $urandom_range(30, 80);
      end else if (r < 92) begin
        v = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        v = 1'b0;
        len = $urandom_range(10, 40);
      end
      out_ch.ready <= v;
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic logic [3*NormW-1:0] pack_normal(logic [NormW-1:0] x, logic [NormW-1:0] y,
                                                     logic [NormW-1:0] z);
    return {z, y, x};
  endfunction

  function automatic coord_t rand_coord(int bits);
    coord_t v;
    v = coord_t'($urandom);
    return v >>> (CoordW - bits);
  endfunction

  function automatic int rand_mag();
    int k;
    k = $urandom_range(0, 9);
    return (k < 4) ? 12 : ((k < 8) ? 18 : CoordW);
  endfunction

  function automatic ent_rec_t make_entity(logic rot, coord_t px, coord_t py, coord_t pz,
                                           coord_t nx, coord_t ny, coord_t nz,
                                           coord_t xx, coord_t xy, coord_t xz,
                                           logic [CoordW-2:0] r);
    ent_rec_t e;
    e.rotated = rot;
    e.pos_x = px;
    e.pos_y = py;
    e.pos_z = pz;
    e.min_x = nx;
    e.min_y = ny;
    e.min_z = nz;
    e.max_x = xx;
    e.max_y = xy;
    e.max_z = xz;
    e.radius = r;
    return e;
  endfunction

  function automatic ent_rec_t rand_entity();
    ent_rec_t e;
    coord_t t;
    int pb, bb;
    logic [CoordW-2:0] r;
    pb = rand_mag();
    bb = rand_mag();
    e.rotated = 1'($urandom_range(0, 1));
    e.pos_x = rand_coord(pb);
    e.pos_y = rand_coord(pb);
    e.pos_z = rand_coord(pb);
    e.min_x = rand_coord(bb);
    e.min_y = rand_coord(bb);
    e.min_z = rand_coord(bb);
    e.max_x = rand_coord(bb);
    e.max_y = rand_coord(bb);
    e.max_z = rand_coord(bb);
    // most boxes well formed, the rest left unsorted and possibly inverted
    if ($urandom_range(0, 4) != 0) begin
      if (e.min_x > e.max_x) begin t = e.min_x; e.min_x = e.max_x; e.max_x = t; end
      if (e.min_y > e.max_y) begin t = e.min_y; e.min_y = e.max_y; e.max_y = t; end
      if (e.min_z > e.max_z) begin t = e.min_z; e.min_z = e.max_z; e.max_z = t; end
    end
    r = (CoordW-1)'($urandom);
    e.radius = r >> ((CoordW - 1) - (rand_mag() - 1));
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_entity(ent_rec_t e);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.is_rotated   <= e.rotated;
    in_ch.pos_x        <= e.pos_x;
    in_ch.pos_y        <= e.pos_y;
    in_ch.pos_z        <= e.pos_z;
    in_ch.box_min_x    <= e.min_x;
    in_ch.box_min_y    <= e.min_y;
    in_ch.box_min_z    <= e.min_z;
    in_ch.box_max_x    <= e.max_x;
    in_ch.box_max_y    <= e.max_y;
    in_ch.box_max_z    <= e.max_z;
    in_ch.bound_radius <= e.radius;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
    if (e.rotated) rotated_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every result is back and the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxWidth-1:0] idx, logic [ApbDataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_planes(plane_set_e kind);
    int p, a;
    logic [NormW-1:0] comp;
    unique case (kind)
      PlanesSlab: begin
        normals[0] = pack_normal(16'h4000, 16'h0000, 16'h0000);
        normals[1] = pack_normal(16'hc000, 16'h0000, 16'h0000);
        normals[2] = pack_normal(16'h0000, 16'h4000, 16'h0000);
        normals[3] = pack_normal(16'h0000, 16'h0000, 16'hc000);
        for (p = 0; p < PlaneCount; p++) dists[p] = -SlabHalf;
      end
      PlanesExtreme: begin
        normals[0] = pack_normal(16'h7fff, 16'h7fff, 16'h7fff);
        normals[1] = pack_normal(16'h8000, 16'h8000, 16'h8000);
        normals[2] = pack_normal(16'h8000, 16'h7fff, 16'h0000);
        normals[3] = pack_normal(16'h0000, 16'h0000, 16'h0000);
        dists[0] = CoordMax;
        dists[1] = CoordMin;
        dists[2] = '0;
        dists[3] = CoordMin;
      end
      default: begin
        for (p = 0; p < PlaneCount; p++) begin
          for (a = 0; a < AxisCount; a++) begin
            comp = NormW'($urandom);
            if ($urandom_range(0, 3) == 0) comp = $signed(comp) >>> 6;
            if (kind == PlanesSparse && $urandom_range(0, 2) == 0) comp = '0;
            normals[p][a*NormW +: NormW] = comp;
          end
          dists[p] = rand_coord(rand_mag());
        end
      end
    endcase
    for (p = 0; p < PlaneCount; p++) begin
      write_reg(RegIdxWidth'(RegNormalBase + p),
                {{(ApbDataWidth-3*NormW){1'b0}}, normals[p]});
      write_reg(RegIdxWidth'(RegDistBase + p),
                {{(ApbDataWidth-CoordW){dists[p][CoordW-1]}}, dists[p]});
    end
    settings_count++;
  endtask

  initial begin
    int phase, k;
    plane_set_e kind;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.is_rotated   <= 1'b0;
    in_ch.pos_x        <= '0;
    in_ch.pos_y        <= '0;
    in_ch.pos_z        <= '0;
    in_ch.box_min_x    <= '0;
    in_ch.box_min_y    <= '0;
    in_ch.box_min_z    <= '0;
    in_ch.box_max_x    <= '0;
    in_ch.box_max_y    <= '0;
    in_ch.box_max_z    <= '0;
    in_ch.bound_radius <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // planes still at reset: zero normals, zero distances
    send_entity(make_entity(1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_entity(make_entity(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_entity(make_entity(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, 23'd1));
    send_entity(make_entity(1'b0, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin,
                            CoordMax, CoordMin, CoordMax, 23'h7fffff));
    drain();

    // slab frustum: edges of the strict box test and the inclusive sphere test
    program_planes(PlanesSlab);
    send_entity(make_entity(1'b0, '0, '0, '0, -24'sd256, -24'sd256, -24'sd256,
                            24'sd256, 24'sd256, 24'sd256, '0));
    send_entity(make_entity(1'b0, -SlabHalf - 24'sd1, '0, '0, -24'sd10, '0, '0,
                            '0, '0, '0, '0));
    send_entity(make_entity(1'b0, -SlabHalf, '0, '0, -24'sd10, '0, '0, '0, '0, '0, '0));
    send_entity(make_entity(1'b0, SlabHalf + 24'sd1, '0, '0, '0, '0, '0,
                            24'sd10, '0, '0, '0));
    send_entity(make_entity(1'b0, SlabHalf, '0, '0, '0, '0, '0, 24'sd10, '0, '0, '0));
    send_entity(make_entity(1'b1, -SlabHalf - 24'sd100, '0, '0, '0, '0, '0,
                            '0, '0, '0, 23'd100));
    send_entity(make_entity(1'b1, -SlabHalf - 24'sd99, '0, '0, '0, '0, '0,
                            '0, '0, '0, 23'd100));
    send_entity(make_entity(1'b1, '0, SlabHalf + 24'sd5, '0, '0, '0, '0,
                            '0, '0, '0, 23'd5));
    send_entity(make_entity(1'b0, CoordMax, '0, '0, CoordMax, '0, '0, CoordMax, '0, '0, '0));
    send_entity(make_entity(1'b0, CoordMin, '0, '0, CoordMin, '0, '0, CoordMin, '0, '0, '0));
    send_entity(make_entity(1'b0, '0, '0, '0, 24'sd256, '0, '0, -24'sd256, '0, '0, '0));
    send_entity(make_entity(1'b0, '0, CoordMin, CoordMax, '0, CoordMax, CoordMin,
                            '0, '0, '0, '0));
    send_entity(make_entity(1'b0, '0, '0, CoordMax, '0, '0, '0, '0, '0, '0, '0));
    send_entity(make_entity(1'b1, '0, '0, '0, CoordMin, CoordMin, CoordMin,
                            CoordMax, CoordMax, CoordMax, 23'h7fffff));
    send_entity(make_entity(1'b1, CoordMin, CoordMin, CoordMax, '0, '0, '0,
                            '0, '0, '0, '0));
    send_entity(make_entity(1'b1, CoordMax, CoordMax, CoordMin, '0, '0, '0,
                            '0, '0, '0, 23'h7fffff));

    for (phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0:       kind = PlanesSlab;
        1:       kind = PlanesExtreme;
        4:       kind = PlanesSparse;
        default: kind = PlanesRandom;
      endcase
      if (phase != 0) begin
        drain();
        program_planes(kind);
      end
      for (k = 0; k < PhaseItems; k++) begin
        if (k % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        send_entity(rand_entity());
      end
    end

    drain();
    repeat (LatencyCycles * 4) @(posedge clk_i);
    $display("%0d entities (%0d as spheres) checked across %0d plane settings", sent,
             rotated_sent, settings_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fbsc_pkg.sv
hdl/fbsc_in_if.sv
hdl/fbsc_out_if.sv
hdl/frustum_box_sphere_cull.sv
tb/sv/cull_monitor.sv
tb/sv/testbench.sv
